// File: hdl/dhl_pkg.sv
// Shared types, codes and constants of the dual-header length deframer.
`timescale 1ns / 1ps
`default_nettype none

package dhl_pkg;

  localparam logic [7:0] SYNC_CMD_HI = 8'hEC;
  localparam logic [7:0] SYNC_CMD_LO = 8'h91;
  localparam logic [7:0] SYNC_IMG_HI = 8'hEB;
  localparam logic [7:0] SYNC_IMG_LO = 8'h92;
  localparam logic [7:0] FOOTER_HI   = 8'hFB;
  localparam logic [7:0] FOOTER_LO   = 8'h92;

  localparam int HDR_BYTES = 5;

  // Register reset values
  localparam logic [31:0] CMD_LIMIT_RESET = 32'd10485760;
  localparam logic [31:0] IMG_LIMIT_RESET = 32'd52428800;
  localparam logic [7:0]  HB_TYPE_RESET   = 8'h11;
  localparam logic [7:0]  ACK_TYPE_RESET  = 8'h12;

  // Register indexes
  localparam logic [7:0] REG_CMD_LIMIT = 8'd0;
  localparam logic [7:0] REG_IMG_LIMIT = 8'd1;
  localparam logic [7:0] REG_HB_TYPE   = 8'd2;
  localparam logic [7:0] REG_ACK_TYPE  = 8'd3;

  // Result kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_IMAGE = 2'd2;

  // Image end status
  localparam logic [1:0] IMG_GOOD     = 2'd0;
  localparam logic [1:0] IMG_BAD_SUM  = 2'd1;
  localparam logic [1:0] IMG_BAD_FOOT = 2'd2;

  typedef struct packed {
    logic [31:0] cmd_limit;
    logic [31:0] img_limit;
    logic [7:0]  hb_type;
    logic [7:0]  ack_type;
  } dhl_cfg_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  frame_type;
    logic [7:0]  payload_byte;
    logic        end_of_frame;
    logic [7:0]  ack_status;
    logic [1:0]  image_status;
    logic [15:0] rect_left;
    logic [15:0] rect_top;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
  } dhl_result_t;

endpackage

`default_nettype wire

// File: hdl/dhl_ifs.sv
// Channel interfaces: received bytes, deframed items and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface dhl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

interface dhl_tx_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  frame_type;
  logic [7:0]  payload_byte;
  logic        end_of_frame;
  logic [7:0]  ack_status;
  logic [1:0]  image_status;
  logic [15:0] rect_left;
  logic [15:0] rect_top;
  logic [15:0] rect_width;
  logic [15:0] rect_height;

  modport source (
    output valid, output item_kind, output frame_type, output payload_byte,
    output end_of_frame, output ack_status, output image_status,
    output rect_left, output rect_top, output rect_width, output rect_height,
    input ready
  );
  modport sink (
    input valid, input item_kind, input frame_type, input payload_byte,
    input end_of_frame, input ack_status, input image_status,
    input rect_left, input rect_top, input rect_width, input rect_height,
    output ready
  );
endinterface

interface dhl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [31:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/dual_header_length_deframer.sv
// Top level of the dual-header length deframer.
// A result is registered in the result register (or in the skid stage while tx stalls) as its byte is taken.
// Throughput: one byte per cycle while rx.ready is high; per-byte work is compares,
// one 32-bit counter and an 8-bit sum between the parser state and the result register.
// rx.ready falls only while both the result register and the skid stage are full.
// Reset (rst, synchronous) clears the parser, empties the output and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module dual_header_length_deframer (
  input  wire      clk,
  input  wire      rst,
  dhl_rx_if.sink   rx,
  dhl_tx_if.source tx,
  dhl_cfg_if.sink  cfg
);
  import dhl_pkg::*;

  dhl_cfg_t    regs;
  logic        accept;
  logic        res_valid;
  dhl_result_t res;
  logic        can_take;
  dhl_result_t out_data;

  assign rx.ready = can_take;
  assign accept   = rx.valid && can_take;

  dhl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dhl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .restart   (rx.restart),
    .regs      (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  dhl_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_data  (out_data)
  );

  assign tx.item_kind    = out_data.item_kind;
  assign tx.frame_type   = out_data.frame_type;
  assign tx.payload_byte = out_data.payload_byte;
  assign tx.end_of_frame = out_data.end_of_frame;
  assign tx.ack_status   = out_data.ack_status;
  assign tx.image_status = out_data.image_status;
  assign tx.rect_left    = out_data.rect_left;
  assign tx.rect_top     = out_data.rect_top;
  assign tx.rect_width   = out_data.rect_width;
  assign tx.rect_height  = out_data.rect_height;

endmodule

`default_nettype wire

// File: hdl/dhl_cfg_regs.sv
// Configuration register bank: limits and type codes.
`timescale 1ns / 1ps
`default_nettype none

module dhl_cfg_regs (
  input  wire              clk,
  input  wire              rst,
  dhl_cfg_if.sink          cfg,
  output dhl_pkg::dhl_cfg_t regs
);
  import dhl_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.cmd_limit <= CMD_LIMIT_RESET;
      regs.img_limit <= IMG_LIMIT_RESET;
      regs.hb_type   <= HB_TYPE_RESET;
      regs.ack_type  <= ACK_TYPE_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_CMD_LIMIT: regs.cmd_limit <= cfg.data;
        REG_IMG_LIMIT: regs.img_limit <= cfg.data;
        REG_HB_TYPE:   regs.hb_type   <= cfg.data[7:0];
        REG_ACK_TYPE:  regs.ack_type  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/dhl_parser.sv
// Frame parser: sync hunt, header decode, payload and image phases, one byte a cycle while accept is high.
`timescale 1ns / 1ps
`default_nettype none

module dhl_parser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  wire  [7:0]           rx_byte,
  input  wire                  restart,
  input  dhl_pkg::dhl_cfg_t    regs,
  output logic                 res_valid,
  output dhl_pkg::dhl_result_t res
);
  import dhl_pkg::*;

  localparam logic [3:0] PH_HUNT      = 4'd0;
  localparam logic [3:0] PH_HEADER    = 4'd1;
  localparam logic [3:0] PH_CMD_DROP  = 4'd2;
  localparam logic [3:0] PH_CMD_PASS  = 4'd3;
  localparam logic [3:0] PH_ACK_HI    = 4'd4;
  localparam logic [3:0] PH_ACK_LO    = 4'd5;
  localparam logic [3:0] PH_IMG_RECT  = 4'd6;
  localparam logic [3:0] PH_IMG_DATA  = 4'd7;
  localparam logic [3:0] PH_IMG_SUM   = 4'd8;
  localparam logic [3:0] PH_IMG_FOOT1 = 4'd9;
  localparam logic [3:0] PH_IMG_FOOT2 = 4'd10;

  logic [3:0]  phase, phase_next;
  logic [7:0]  prev, prev_next;
  logic [7:0]  held [HDR_BYTES];
  logic [7:0]  held_next [HDR_BYTES];
  logic [2:0]  hcount, hcount_next;
  logic        is_img, is_img_next;
  logic [31:0] remaining, remaining_next;
  logic [7:0]  rsum, rsum_next;
  logic [15:0] rect [4];
  logic [15:0] rect_next [4];
  logic        cbad, cbad_next;

  logic [7:0]  again [HDR_BYTES];
  logic [31:0] len;
  logic [31:0] limit;
  logic        over;
  logic [3:0]  pair_hit;
  logic        found;
  logic [1:0]  sel;
  logic        hunt_hit;

  assign len   = {held[1], held[2], held[3], rx_byte};
  assign limit = is_img ? regs.img_limit : regs.cmd_limit;
  assign over  = len > limit;
  assign hunt_hit = (prev == SYNC_CMD_HI && rx_byte == SYNC_CMD_LO) ||
                    (prev == SYNC_IMG_HI && rx_byte == SYNC_IMG_LO);

  // Header bytes as they stand once the fifth byte lands, for the rescan
  always_comb begin
    for (int i = 0; i < HDR_BYTES - 1; i++) again[i] = held[i];
    again[HDR_BYTES-1] = rx_byte;
  end

  // First sync word among the held bytes wins
  always_comb begin
    found = 1'b0;
    sel   = 2'd0;
    for (int i = 0; i < HDR_BYTES - 1; i++) begin
      pair_hit[i] = (again[i] == SYNC_CMD_HI && again[i+1] == SYNC_CMD_LO) ||
                    (again[i] == SYNC_IMG_HI && again[i+1] == SYNC_IMG_LO);
    end
    for (int i = HDR_BYTES - 2; i >= 0; i--) begin
      if (pair_hit[i]) begin
        found = 1'b1;
        sel   = 2'(i);
      end
    end
  end

  always_comb begin
    phase_next     = phase;
    prev_next      = prev;
    held_next      = held;
    hcount_next    = hcount;
    is_img_next    = is_img;
    remaining_next = remaining;
    rsum_next      = rsum;
    rect_next      = rect;
    cbad_next      = cbad;
    res_valid      = 1'b0;
    res            = '0;
    res.frame_type = held[0];

    if (accept) begin
      if (restart) begin
        phase_next     = PH_HUNT;
        prev_next      = '0;
        for (int i = 0; i < HDR_BYTES; i++) held_next[i] = '0;
        hcount_next    = '0;
        is_img_next    = 1'b0;
        remaining_next = '0;
        rsum_next      = '0;
        for (int i = 0; i < 4; i++) rect_next[i] = '0;
        cbad_next      = 1'b0;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (hunt_hit) begin
              is_img_next = (prev == SYNC_IMG_HI);
              hcount_next = '0;
              phase_next  = PH_HEADER;
              prev_next   = '0;
            end else begin
              prev_next = rx_byte;
            end
          end
          PH_HEADER: begin
            held_next[hcount] = rx_byte;
            hcount_next = hcount + 3'd1;
            if (hcount == 3'(HDR_BYTES - 1)) begin
              hcount_next = '0;
              if (over) begin
                // Drop the sync word and hunt again through the held bytes
                if (found) begin
                  phase_next  = PH_HEADER;
                  prev_next   = '0;
                  is_img_next = (again[sel] == SYNC_IMG_HI);
                  hcount_next = 3'd3 - {1'b0, sel};
                  for (int k = 0; k < 3; k++) begin
                    if (3'(k) < hcount_next) begin
                      held_next[k] = again[3'(k) + {1'b0, sel} + 3'd2];
                    end
                  end
                end else begin
                  phase_next = PH_HUNT;
                  prev_next  = rx_byte;
                end
              end else begin
                remaining_next = len;
                if (is_img) begin
                  rsum_next = 8'(SYNC_IMG_HI + SYNC_IMG_LO + held[0] + held[1] +
                                 held[2] + held[3] + rx_byte);
                  cbad_next  = 1'b0;
                  phase_next = PH_IMG_RECT;
                end else if (held[0] == regs.ack_type && len == 32'd2) begin
                  phase_next = PH_ACK_HI;
                end else if (len == 32'd0) begin
                  phase_next = PH_HUNT;
                  prev_next  = '0;
                end else if (held[0] == regs.hb_type) begin
                  phase_next = PH_CMD_DROP;
                end else begin
                  phase_next = PH_CMD_PASS;
                end
              end
            end
          end
          PH_CMD_DROP: begin
            remaining_next = remaining - 32'd1;
            if (remaining == 32'd1) begin
              phase_next = PH_HUNT;
              prev_next  = '0;
            end
          end
          PH_CMD_PASS: begin
            remaining_next   = remaining - 32'd1;
            res_valid        = 1'b1;
            res.item_kind    = KIND_CMD;
            res.payload_byte = rx_byte;
            res.end_of_frame = (remaining == 32'd1);
            if (remaining == 32'd1) begin
              phase_next = PH_HUNT;
              prev_next  = '0;
            end
          end
          PH_ACK_HI: begin
            phase_next = PH_ACK_LO;
          end
          PH_ACK_LO: begin
            res_valid        = 1'b1;
            res.item_kind    = KIND_ACK;
            res.end_of_frame = 1'b1;
            res.ack_status   = rx_byte;
            phase_next       = PH_HUNT;
            prev_next        = '0;
          end
          PH_IMG_RECT: begin
            if (!hcount[0]) begin
              rect_next[hcount[2:1]] = {rx_byte, 8'h00};
            end else begin
              rect_next[hcount[2:1]] = {rect[hcount[2:1]][15:8], rx_byte};
            end
            hcount_next = hcount + 3'd1;
            if (hcount == 3'd7) begin
              hcount_next = '0;
              phase_next  = (remaining == 32'd0) ? PH_IMG_SUM : PH_IMG_DATA;
            end
          end
          PH_IMG_DATA: begin
            remaining_next   = remaining - 32'd1;
            res_valid        = 1'b1;
            res.item_kind    = KIND_IMAGE;
            res.payload_byte = rx_byte;
            if (remaining == 32'd1) phase_next = PH_IMG_SUM;
          end
          PH_IMG_SUM: begin
            cbad_next  = (rx_byte != rsum);
            phase_next = PH_IMG_FOOT1;
          end
          PH_IMG_FOOT1: begin
            prev_next  = rx_byte;
            phase_next = PH_IMG_FOOT2;
          end
          default: begin
            // Second footer byte: report the image
            res_valid        = 1'b1;
            res.item_kind    = KIND_IMAGE;
            res.end_of_frame = 1'b1;
            if (cbad) begin
              res.image_status = IMG_BAD_SUM;
            end else if (prev != FOOTER_HI || rx_byte != FOOTER_LO) begin
              res.image_status = IMG_BAD_FOOT;
            end else begin
              res.image_status = IMG_GOOD;
            end
            res.rect_left   = rect[0];
            res.rect_top    = rect[1];
            res.rect_width  = rect[2];
            res.rect_height = rect[3];
            phase_next      = PH_HUNT;
            prev_next       = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      prev      <= '0;
      hcount    <= '0;
      is_img    <= 1'b0;
      remaining <= '0;
      rsum      <= '0;
      cbad      <= 1'b0;
      for (int i = 0; i < HDR_BYTES; i++) held[i] <= '0;
      for (int i = 0; i < 4; i++) rect[i] <= '0;
    end else begin
      phase     <= phase_next;
      prev      <= prev_next;
      hcount    <= hcount_next;
      is_img    <= is_img_next;
      remaining <= remaining_next;
      rsum      <= rsum_next;
      cbad      <= cbad_next;
      held      <= held_next;
      rect      <= rect_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dhl_out_buf.sv
// Result register with a skid stage behind it.
`timescale 1ns / 1ps
`default_nettype none

module dhl_out_buf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  dhl_pkg::dhl_result_t push_data,
  output logic                 can_take,
  output logic                 out_valid,
  input  wire                  out_ready,
  output dhl_pkg::dhl_result_t out_data
);
  import dhl_pkg::*;

  logic        skid_valid;
  dhl_result_t skid_data;
  logic        pop;

  assign pop      = out_valid && out_ready;
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        // Advance the skid entry; a new result takes its place
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dhl_checker.sv
// Port-level checks on the deframer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dhl_checker (
  input wire       clk,
  input wire       rst,
  input wire       rx_valid,
  input wire       rx_ready,
  input wire       rx_restart,
  input wire       tx_valid,
  input wire       tx_ready,
  input wire [1:0] tx_item_kind,
  input wire [7:0] tx_payload_byte,
  input wire       tx_end_of_frame,
  input wire [1:0] tx_image_status
);
  import dhl_pkg::*;

  // A stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_payload_byte) &&
                              $stable(tx_item_kind))
    else $error("stalled output transaction changed");

  assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("output valid after reset");

  // A restart with nothing queued never makes a result
  assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready && rx_restart && !tx_valid |=> !tx_valid)
    else $error("restart produced a result");

  assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_item_kind == KIND_ACK |-> tx_end_of_frame && tx_payload_byte == 8'h00)
    else $error("ack item malformed");

  assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_image_status != IMG_GOOD |->
      tx_item_kind == KIND_IMAGE && tx_end_of_frame)
    else $error("image status outside image end");

endmodule

bind dual_header_length_deframer dhl_checker u_dhl_checker (
  .clk             (clk),
  .rst             (rst),
  .rx_valid        (rx.valid),
  .rx_ready        (rx.ready),
  .rx_restart      (rx.restart),
  .tx_valid        (tx.valid),
  .tx_ready        (tx.ready),
  .tx_item_kind    (tx.item_kind),
  .tx_payload_byte (tx.payload_byte),
  .tx_end_of_frame (tx.end_of_frame),
  .tx_image_status (tx.image_status)
);

`default_nettype wire
